// ----- design/cau_pkg.sv -----
// shared types and constants for the complex arithmetic unit
`default_nettype none
package cau_pkg;

	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;
	localparam int KIND_BITS     = 3;

	typedef enum logic [KIND_BITS-1:0] {
		KIND_ADD  = 3'd0,
		KIND_SUB  = 3'd1,
		KIND_MUL  = 3'd2,
		KIND_DIV  = 3'd3,
		KIND_NEG  = 3'd4,
		KIND_CONJ = 3'd5,
		KIND_MAG  = 3'd6,
		KIND_NONE = 3'd7
	} kind_t;

endpackage
`default_nettype wire

// ----- design/cau_prep.sv -----
// product stage and operand set-up feeding the divide and root cell chain
`default_nettype none
module cau_prep #(
	parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF,
	parameter int SIDE_BITS = cau_pkg::KIND_BITS + 2*WORD_BITS + 6
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         in_valid,
	input  wire logic [cau_pkg::KIND_BITS-1:0] in_kind,
	input  wire logic signed [WORD_BITS-1:0]  a_real,
	input  wire logic signed [WORD_BITS-1:0]  a_imag,
	input  wire logic signed [WORD_BITS-1:0]  b_real,
	input  wire logic signed [WORD_BITS-1:0]  b_imag,
	output logic                              out_valid,
	output logic [SIDE_BITS-1:0]              out_side,
	output logic [2*WORD_BITS-1:0]            out_den,
	output logic [2*WORD_BITS-1:0]            out_rem_re,
	output logic [WORD_BITS-1:0]              out_nq_re,
	output logic [2*WORD_BITS-1:0]            out_rem_im,
	output logic [WORD_BITS-1:0]              out_nq_im,
	output logic [2*WORD_BITS-1:0]            out_rad
);
	import cau_pkg::*;

	localparam int W  = WORD_BITS;
	localparam int F  = FRAC_BITS;
	localparam int PW = 2*W + 1;
	localparam int NW = 2*W + F;

	logic                   valid_s1;
	logic [KIND_BITS-1:0]   kind_s1;
	logic signed [W-1:0]    ar_s1, ai_s1, br_s1, bi_s1;
	logic signed [2*W-1:0]  prr_s1, pii_s1, pri_s1, pir_s1, paa_s1, pbb_s1, pdr_s1, pdi_s1;

	logic                   valid_s2;
	logic [SIDE_BITS-1:0]   side_s2;
	logic [2*W-1:0]         den_s2, rem_re_s2, rem_im_s2, rad_s2;
	logic [W-1:0]           nq_re_s2, nq_im_s2;

	function automatic logic [W:0] sat_fn(input logic signed [PW-1:0] v);
		logic [W:0] r;
		if (v[PW-1:W-1] == '0 || v[PW-1:W-1] == '1) begin
			r = {1'b0, v[W-1:0]};
		end else if (v[PW-1]) begin
			r = {1'b1, 1'b1, {(W-1){1'b0}}};
		end else begin
			r = {1'b1, 1'b0, {(W-1){1'b1}}};
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_s1 <= in_kind;
			ar_s1   <= a_real;
			ai_s1   <= a_imag;
			br_s1   <= b_real;
			bi_s1   <= b_imag;
			prr_s1  <= a_real * b_real;
			pii_s1  <= a_imag * b_imag;
			pri_s1  <= a_real * b_imag;
			pir_s1  <= a_imag * b_real;
			paa_s1  <= a_real * a_real;
			pbb_s1  <= a_imag * a_imag;
			pdr_s1  <= b_real * b_real;
			pdi_s1  <= b_imag * b_imag;
		end
	end

	logic signed [PW-1:0] v_re, v_im, mre, mim, nr, ni;
	logic [W:0]           s_re, s_im;
	logic [2*W-1:0]       abs_re, abs_im, den;
	logic [NW-1:0]        n_re, n_im;
	logic                 ovf_re, ovf_im, dz;

	always_comb begin
		mre = (PW'(prr_s1) - PW'(pii_s1)) >>> F;
		mim = (PW'(pri_s1) + PW'(pir_s1)) >>> F;
		nr  = PW'(prr_s1) + PW'(pii_s1);
		ni  = PW'(pir_s1) - PW'(pri_s1);
		case (kind_s1)
			KIND_ADD: begin
				v_re = PW'(ar_s1) + PW'(br_s1);
				v_im = PW'(ai_s1) + PW'(bi_s1);
			end
			KIND_SUB: begin
				v_re = PW'(ar_s1) - PW'(br_s1);
				v_im = PW'(ai_s1) - PW'(bi_s1);
			end
			KIND_MUL: begin
				v_re = mre;
				v_im = mim;
			end
			KIND_NEG: begin
				v_re = -PW'(ar_s1);
				v_im = -PW'(ai_s1);
			end
			KIND_CONJ: begin
				v_re = PW'(ar_s1);
				v_im = -PW'(ai_s1);
			end
			default: begin
				v_re = '0;
				v_im = '0;
			end
		endcase
		s_re   = sat_fn(v_re);
		s_im   = sat_fn(v_im);
		abs_re = nr[PW-1] ? (2*W)'(-nr) : (2*W)'(nr);
		abs_im = ni[PW-1] ? (2*W)'(-ni) : (2*W)'(ni);
		den    = pdr_s1 + pdi_s1;
		n_re   = {abs_re, {F{1'b0}}};
		n_im   = {abs_im, {F{1'b0}}};
		ovf_re = NW'(n_re[NW-1:W]) >= NW'(den);
		ovf_im = NW'(n_im[NW-1:W]) >= NW'(den);
		dz     = (br_s1 == '0) && (bi_s1 == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s2   <= {ni[PW-1], ovf_im, nr[PW-1], ovf_re, dz, s_re[W] | s_im[W],
				s_im[W-1:0], s_re[W-1:0], kind_s1};
			den_s2    <= den;
			rem_re_s2 <= (2*W)'(n_re[NW-1:W]);
			rem_im_s2 <= (2*W)'(n_im[NW-1:W]);
			nq_re_s2  <= n_re[W-1:0];
			nq_im_s2  <= n_im[W-1:0];
			rad_s2    <= paa_s1 + pbb_s1;
		end
	end

	assign out_valid  = valid_s2;
	assign out_side   = side_s2;
	assign out_den    = den_s2;
	assign out_rem_re = rem_re_s2;
	assign out_nq_re  = nq_re_s2;
	assign out_rem_im = rem_im_s2;
	assign out_nq_im  = nq_im_s2;
	assign out_rad    = rad_s2;

endmodule
`default_nettype wire

// ----- design/cau_cell.sv -----
// one cell of the chain: a quotient bit on both divide lanes and a root bit
`default_nettype none
module cau_cell #(
	parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
	parameter int SIDE_BITS = cau_pkg::KIND_BITS + 2*WORD_BITS + 6
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic                   in_valid,
	input  wire logic [SIDE_BITS-1:0]   in_side,
	input  wire logic [2*WORD_BITS-1:0] in_den,
	input  wire logic [2*WORD_BITS-1:0] in_rem_re,
	input  wire logic [WORD_BITS-1:0]   in_nq_re,
	input  wire logic [2*WORD_BITS-1:0] in_rem_im,
	input  wire logic [WORD_BITS-1:0]   in_nq_im,
	input  wire logic [2*WORD_BITS-1:0] in_rad,
	input  wire logic [WORD_BITS+1:0]   in_srem,
	input  wire logic [WORD_BITS-1:0]   in_sq,
	output logic                        out_valid,
	output logic [SIDE_BITS-1:0]        out_side,
	output logic [2*WORD_BITS-1:0]      out_den,
	output logic [2*WORD_BITS-1:0]      out_rem_re,
	output logic [WORD_BITS-1:0]        out_nq_re,
	output logic [2*WORD_BITS-1:0]      out_rem_im,
	output logic [WORD_BITS-1:0]        out_nq_im,
	output logic [2*WORD_BITS-1:0]      out_rad,
	output logic [WORD_BITS+1:0]        out_srem,
	output logic [WORD_BITS-1:0]        out_sq
);
	localparam int W = WORD_BITS;

	logic                 valid_q;
	logic [SIDE_BITS-1:0] side_q;
	logic [2*W-1:0]       den_q, rem_re_q, rem_im_q, rad_q;
	logic [W-1:0]         nq_re_q, nq_im_q, sq_q;
	logic [W+1:0]         srem_q;

	logic [2*W:0]   t_re, t_im, d_re, d_im;
	logic [W+3:0]   t_sq, trial, d_sq;
	logic           b_re, b_im, b_sq;

	always_comb begin
		t_re  = {in_rem_re, in_nq_re[W-1]};
		t_im  = {in_rem_im, in_nq_im[W-1]};
		d_re  = t_re - {1'b0, in_den};
		d_im  = t_im - {1'b0, in_den};
		b_re  = t_re >= {1'b0, in_den};
		b_im  = t_im >= {1'b0, in_den};
		t_sq  = {in_srem, in_rad[2*W-1:2*W-2]};
		trial = (W+4)'({in_sq, 2'b01});
		d_sq  = t_sq - trial;
		b_sq  = t_sq >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_q   <= in_side;
			den_q    <= in_den;
			rem_re_q <= b_re ? d_re[2*W-1:0] : t_re[2*W-1:0];
			rem_im_q <= b_im ? d_im[2*W-1:0] : t_im[2*W-1:0];
			nq_re_q  <= {in_nq_re[W-2:0], b_re};
			nq_im_q  <= {in_nq_im[W-2:0], b_im};
			rad_q    <= {in_rad[2*W-3:0], 2'b00};
			srem_q   <= b_sq ? d_sq[W+1:0] : t_sq[W+1:0];
			sq_q     <= {in_sq[W-2:0], b_sq};
		end
	end

	assign out_valid  = valid_q;
	assign out_side   = side_q;
	assign out_den    = den_q;
	assign out_rem_re = rem_re_q;
	assign out_nq_re  = nq_re_q;
	assign out_rem_im = rem_im_q;
	assign out_nq_im  = nq_im_q;
	assign out_rad    = rad_q;
	assign out_srem   = srem_q;
	assign out_sq     = sq_q;

endmodule
`default_nettype wire

// ----- design/complex_arith_unit_core.sv -----
// top level of the complex arithmetic unit
// complex add, sub, mul, div, negate, conjugate and magnitude on signed fixed point
// input channel s_*: tdata carries a_real, a_imag, b_real, b_imag (lowest first),
// tuser the operation kind; a word is taken when s_tvalid and s_tready are high
// output channel m_*: tdata carries res_real, res_imag, tuser saturated, div_by_zero
// one word in per cycle and one result out per cycle while the receiver is not stalling, results in order
// the pipeline is one product stage, one set-up stage,
// a chain of WORD_BITS cells each settling one quotient bit and one root bit,
// and the output register
// the whole pipeline advances together; when the receiver stalls with a result
// waiting, every stage holds and s_tready drops until m_tready returns
// the output register holds its word steady while stalled
// reset empties the pipeline; no result is shown until new words arrive
`default_nettype none
module complex_arith_unit_core #(
	parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// a_real, a_imag, b_real, b_imag
	input  wire logic [((4*WORD_BITS+7)/8)*8-1:0]     s_tdata,
	// kind
	input  wire logic [cau_pkg::KIND_BITS-1:0]        s_tuser,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// res_real, res_imag
	output logic [((2*WORD_BITS+7)/8)*8-1:0]          m_tdata,
	// saturated, div_by_zero
	output logic [1:0]                                m_tuser
);
	import cau_pkg::*;

	localparam int W   = WORD_BITS;
	localparam int SB  = KIND_BITS + 2*W + 6;
	localparam int ODW = ((2*W+7)/8)*8;

	logic en;
	logic out_valid_q;
	logic [W-1:0] res_re_q, res_im_q;
	logic sat_q, dz_q;

	logic             c_valid [0:W];
	logic [SB-1:0]    c_side  [0:W];
	logic [2*W-1:0]   c_den   [0:W];
	logic [2*W-1:0]   c_rre   [0:W];
	logic [W-1:0]     c_qre   [0:W];
	logic [2*W-1:0]   c_rim   [0:W];
	logic [W-1:0]     c_qim   [0:W];
	logic [2*W-1:0]   c_rad   [0:W];
	logic [W+1:0]     c_srem  [0:W];
	logic [W-1:0]     c_sq    [0:W];

	assign en       = !out_valid_q || m_tready;
	assign s_tready = en;

	cau_prep #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS), .SIDE_BITS(SB)) u_prep (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.in_valid   (s_tvalid),
		.in_kind    (s_tuser),
		.a_real     (s_tdata[W-1:0]),
		.a_imag     (s_tdata[2*W-1:W]),
		.b_real     (s_tdata[3*W-1:2*W]),
		.b_imag     (s_tdata[4*W-1:3*W]),
		.out_valid  (c_valid[0]),
		.out_side   (c_side[0]),
		.out_den    (c_den[0]),
		.out_rem_re (c_rre[0]),
		.out_nq_re  (c_qre[0]),
		.out_rem_im (c_rim[0]),
		.out_nq_im  (c_qim[0]),
		.out_rad    (c_rad[0])
	);

	assign c_srem[0] = '0;
	assign c_sq[0]   = '0;

	for (genvar i = 0; i < W; i++) begin : g_cell
		cau_cell #(.WORD_BITS(W), .SIDE_BITS(SB)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.in_valid   (c_valid[i]),
			.in_side    (c_side[i]),
			.in_den     (c_den[i]),
			.in_rem_re  (c_rre[i]),
			.in_nq_re   (c_qre[i]),
			.in_rem_im  (c_rim[i]),
			.in_nq_im   (c_qim[i]),
			.in_rad     (c_rad[i]),
			.in_srem    (c_srem[i]),
			.in_sq      (c_sq[i]),
			.out_valid  (c_valid[i+1]),
			.out_side   (c_side[i+1]),
			.out_den    (c_den[i+1]),
			.out_rem_re (c_rre[i+1]),
			.out_nq_re  (c_qre[i+1]),
			.out_rem_im (c_rim[i+1]),
			.out_nq_im  (c_qim[i+1]),
			.out_rad    (c_rad[i+1]),
			.out_srem   (c_srem[i+1]),
			.out_sq     (c_sq[i+1])
		);
	end

	logic [KIND_BITS-1:0] f_kind;
	logic [W-1:0]         f_pre_re, f_pre_im;
	logic                 f_pre_sat, f_dz, f_ovf_re, f_neg_re, f_ovf_im, f_neg_im;
	logic [W:0]           q_re, q_im;
	logic [W-1:0]         n_re, n_im, n_mag;
	logic [W-1:0]         n_mag_sq;
	logic                 n_sat;

	function automatic logic [W:0] fix_fn(input logic ovf, input logic neg,
		input logic [W-1:0] q);
		logic [W:0] r;
		if (neg) begin
			if (ovf || (q[W-1] && q[W-2:0] != '0)) begin
				r = {1'b1, 1'b1, {(W-1){1'b0}}};
			end else begin
				r = {1'b0, -q};
			end
		end else begin
			if (ovf || q[W-1]) begin
				r = {1'b1, 1'b0, {(W-1){1'b1}}};
			end else begin
				r = {1'b0, q};
			end
		end
		return r;
	endfunction

	always_comb begin
		{f_neg_im, f_ovf_im, f_neg_re, f_ovf_re, f_dz, f_pre_sat, f_pre_im, f_pre_re, f_kind}
			= c_side[W];
		q_re     = fix_fn(f_ovf_re, f_neg_re, c_qre[W]);
		q_im     = fix_fn(f_ovf_im, f_neg_im, c_qim[W]);
		n_mag_sq = c_sq[W][W-1] ? {1'b0, {(W-1){1'b1}}} : c_sq[W];
		case (f_kind)
			KIND_DIV: begin
				if (f_dz) begin
					n_re  = '0;
					n_im  = '0;
					n_sat = 1'b0;
				end else begin
					n_re  = q_re[W-1:0];
					n_im  = q_im[W-1:0];
					n_sat = q_re[W] | q_im[W];
				end
			end
			KIND_MAG: begin
				n_re  = n_mag_sq;
				n_im  = '0;
				n_sat = c_sq[W][W-1];
			end
			default: begin
				n_re  = f_pre_re;
				n_im  = f_pre_im;
				n_sat = f_pre_sat;
			end
		endcase
		n_mag = n_re;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= c_valid[W];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_re_q <= n_mag;
			res_im_q <= n_im;
			sat_q    <= n_sat;
			dz_q     <= (f_kind == KIND_DIV) && f_dz;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = ODW'({res_im_q, res_re_q});
	assign m_tuser  = {dz_q, sat_q};

endmodule
`default_nettype wire

// ----- design/cau_checker.sv -----
// port-level checks on the complex arithmetic unit and their binding
`default_nettype none
module cau_port_checker #(
	parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF
) (
	input wire logic                              clk,
	input wire logic                              arst_n,
	input wire logic                              s_tvalid,
	input wire logic                              s_tready,
	input wire logic                              m_tvalid,
	input wire logic                              m_tready,
	input wire logic [((2*WORD_BITS+7)/8)*8-1:0]  m_tdata,
	input wire logic [1:0]                        m_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result word changed while stalled");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid || m_tready |-> s_tready)
		else $error("input stalled with room at the output");

	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tdata == '0 && !m_tuser[0])
		else $error("divide by zero gave a nonzero or saturated result");

	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while the output is stalled");

endmodule

bind complex_arith_unit_core cau_port_checker #(.WORD_BITS(WORD_BITS)) u_cau_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

// ----- sim/cau_checker.sv -----
// result checker for the complex arithmetic unit: predicts each word and compares
`timescale 1ns / 1ps
`default_nettype none
module cau_checker (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	input  wire logic         s_tready,
	input  wire logic [127:0] s_tdata,
	input  wire logic [2:0]   s_tuser,
	input  wire logic         m_tvalid,
	input  wire logic         m_tready,
	input  wire logic [63:0]  m_tdata,
	input  wire logic [1:0]   m_tuser,
	output int                fail_count,
	output int                pending
);
	import cau_pkg::*;

	typedef struct packed {
		logic [31:0] res_real;
		logic [31:0] res_imag;
		logic        saturated;
		logic        div_by_zero;
	} cplx_result_t;

	cplx_result_t expected_results[$];

	function automatic logic [31:0] clip(input logic signed [127:0] v, inout logic flag);
		logic signed [127:0] hi_lim;
		logic signed [127:0] lo_lim;
		hi_lim = 128'sd2147483647;
		lo_lim = -128'sd2147483648;
		if (v > hi_lim) begin
			flag = 1'b1;
			return 32'h7fffffff;
		end
		if (v < lo_lim) begin
			flag = 1'b1;
			return 32'h80000000;
		end
		return v[31:0];
	endfunction

	function automatic cplx_result_t predict_result(input logic [2:0] kind,
			input logic signed [31:0] ar32, input logic signed [31:0] ai32,
			input logic signed [31:0] br32, input logic signed [31:0] bi32);
		logic signed [127:0] ar, ai, br, bi, re, im, den;
		logic [127:0] sq;
		logic [127:0] root;
		logic [127:0] cand;
		cplx_result_t r;
		ar = ar32;
		ai = ai32;
		br = br32;
		bi = bi32;
		re = '0;
		im = '0;
		r = '0;
		case (kind)
			KIND_ADD: begin
				re = ar + br;
				im = ai + bi;
			end
			KIND_SUB: begin
				re = ar - br;
				im = ai - bi;
			end
			KIND_MUL: begin
				re = (ar * br - ai * bi) >>> FRAC_BITS_DEF;
				im = (ar * bi + ai * br) >>> FRAC_BITS_DEF;
			end
			KIND_DIV: begin
				if (br == 0 && bi == 0) begin
					r.div_by_zero = 1'b1;
				end else begin
					den = br * br + bi * bi;
					re = ((ar * br + ai * bi) <<< FRAC_BITS_DEF) / den;
					im = ((ai * br - ar * bi) <<< FRAC_BITS_DEF) / den;
				end
			end
			KIND_NEG: begin
				re = -ar;
				im = -ai;
			end
			KIND_CONJ: begin
				re = ar;
				im = -ai;
			end
			KIND_MAG: begin
				sq = ar * ar + ai * ai;
				root = '0;
				for (int b = 33; b >= 0; b--) begin
					cand = root | (128'd1 << b);
					if (cand * cand <= sq)
						root = cand;
				end
				re = root;
			end
			default: ;
		endcase
		r.res_real = clip(re, r.saturated);
		r.res_imag = clip(im, r.saturated);
		return r;
	endfunction

	cplx_result_t got;
	cplx_result_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_results.push_back(predict_result(s_tuser, s_tdata[31:0],
					s_tdata[63:32], s_tdata[95:64], s_tdata[127:96]));
			if (m_tvalid && m_tready) begin
				got = {m_tdata[31:0], m_tdata[63:32], m_tuser[0], m_tuser[1]};
				if (expected_results.size() == 0) begin
					$error("result word with nothing expected");
					fail_count++;
				end else begin
					want = expected_results.pop_front();
					if (got.res_real !== want.res_real) begin
						$error("res_real expected %h actual %h", want.res_real, got.res_real);
						fail_count++;
					end
					if (got.res_imag !== want.res_imag) begin
						$error("res_imag expected %h actual %h", want.res_imag, got.res_imag);
						fail_count++;
					end
					if (got.saturated !== want.saturated) begin
						$error("saturated expected %b actual %b", want.saturated,
							got.saturated);
						fail_count++;
					end
					if (got.div_by_zero !== want.div_by_zero) begin
						$error("div_by_zero expected %b actual %b", want.div_by_zero,
							got.div_by_zero);
						fail_count++;
					end
				end
			end
		end
		pending = expected_results.size();
	end

	initial begin
		fail_count = 0;
		pending = 0;
	end
endmodule
`default_nettype wire

// ----- sim/tb_complex_arith_unit_core.sv -----
// testbench top for the complex arithmetic unit: stimulus, back-pressure and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_complex_arith_unit_core;
	import cau_pkg::*;

	localparam int LATENCY = WORD_BITS_DEF + 3;
	localparam int CYCLE_LIMIT = 400000;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_tvalid = 1'b0;
	logic         s_tready;
	logic [127:0] s_tdata = '0;
	logic [2:0]   s_tuser = '0;
	logic         m_tvalid;
	logic         m_tready = 1'b0;
	logic [63:0]  m_tdata;
	logic [1:0]   m_tuser;
	int           fail_count;
	int           pending;
	int           cycles = 0;
	bit           idle_on = 1'b1;
	bit           hold_req = 1'b0;

	always #2 clk = ~clk;

	complex_arith_unit_core DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	cau_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .pending(pending)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver side, with one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (300) @(negedge clk);
			end
			m_tready <= !(idle_on && $urandom_range(99) < 8);
		end
	end

	task automatic send_word(input logic [2:0] kind, input logic [31:0] ar,
			input logic [31:0] ai, input logic [31:0] br, input logic [31:0] bi);
		while (idle_on && $urandom_range(99) < 8) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {bi, br, ai, ar};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [31:0] pick_operand();
		int sel;
		sel = $urandom_range(99);
		if (sel < 40)
			return $urandom;
		if (sel < 80)
			return 32'($signed($urandom_range(2097152)) - 1048576);
		case ($urandom_range(6))
			0: return 32'h0;
			1: return 32'h7fffffff;
			2: return 32'h80000000;
			3: return 32'h1;
			4: return 32'hffffffff;
			5: return 32'h00010000;
			default: return 32'hffff0000;
		endcase
	endfunction

	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 5) @(negedge clk);
	endtask

	logic [2:0]  kind;
	logic [31:0] br;
	logic [31:0] bi;

	initial begin
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		// directed words
		send_word(KIND_ADD, 32'h7fffffff, 32'h80000000, 32'h1, 32'hffffffff);
		send_word(KIND_ADD, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
		send_word(KIND_SUB, 32'h80000000, 32'h7fffffff, 32'h1, 32'hffffffff);
		send_word(KIND_SUB, 32'h00010000, 32'h00020000, 32'h00030000, 32'h0);
		send_word(KIND_MUL, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h80000000);
		send_word(KIND_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		send_word(KIND_MUL, 32'hffffffff, 32'h0, 32'h1, 32'h0);
		send_word(KIND_MUL, 32'h00018000, 32'hfffe0000, 32'h00020000, 32'h00008000);
		send_word(KIND_DIV, 32'h00010000, 32'h0, 32'h0, 32'h0);
		send_word(KIND_DIV, 32'h7fffffff, 32'h80000000, 32'h1, 32'h0);
		send_word(KIND_DIV, 32'hffffffff, 32'h1, 32'h00030000, 32'h0);
		send_word(KIND_DIV, 32'h80000000, 32'h7fffffff, 32'h80000000, 32'h80000000);
		send_word(KIND_NEG, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
		send_word(KIND_NEG, 32'h7fffffff, 32'h1, 32'hffffffff, 32'hffffffff);
		send_word(KIND_CONJ, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
		send_word(KIND_CONJ, 32'h7fffffff, 32'h7fffffff, 32'h0, 32'h0);
		send_word(KIND_MAG, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
		send_word(KIND_MAG, 32'h00030000, 32'hfffc0000, 32'h0, 32'h0);
		send_word(KIND_MAG, 32'h0, 32'h0, 32'h0, 32'h0);
		send_word(KIND_NONE, 32'h12345678, 32'h9abcdef0, 32'h1, 32'h2);
		drain();
		// random words; middle stretch without idling, one long receiver hold-off
		for (int n = 0; n < 1750; n++) begin
			if (n == 600)
				idle_on = 1'b0;
			if (n == 900)
				idle_on = 1'b1;
			if (n == 1000)
				hold_req = 1'b1;
			if (n == 1400)
				drain();
			kind = ($urandom_range(99) < 3) ? KIND_NONE : 3'($urandom_range(6));
			br = pick_operand();
			bi = pick_operand();
			if (kind == KIND_DIV && $urandom_range(99) < 10) begin
				br = '0;
				bi = '0;
			end
			send_word(kind, pick_operand(), pick_operand(), br, bi);
		end
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (LATENCY + 10) @(negedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
`default_nettype wire
